[sv/clbr_pkg.sv]
// Shared types, constants and helper functions for the character LCD buffer.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package clbr_pkg;

    localparam int MAX_ROWS    = 4;
    localparam int MAX_COLS    = 20;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int INIT_COUNT  = 10;

    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] SET_DDRAM   = 8'h80;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;

    typedef enum logic [2:0] {
        KIND_INIT         = 3'd0,
        KIND_PLACE        = 3'd1,
        KIND_STRING_START = 3'd2,
        KIND_STRING_NEXT  = 3'd3,
        KIND_CLEAR        = 3'd4,
        KIND_REFRESH      = 3'd5
    } kind_t;

    // Register index, taken from the word address
    typedef enum logic [2:0] {
        REG_ROWS           = 3'd0,
        REG_COLS           = 3'd1,
        REG_BACKLIGHT_ON   = 3'd2,
        REG_I2C_ADDRESS    = 3'd3,
        REG_RS_MASK        = 3'd4,
        REG_ENABLE_MASK    = 3'd5,
        REG_BACKLIGHT_MASK = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [2:0] rows;
        logic [4:0] cols;
        logic       backlight_on;
        logic [6:0] i2c_address;
        logic [7:0] rs_mask;
        logic [7:0] enable_mask;
        logic [7:0] backlight_mask;
    } cfg_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        kind_t             kind;
        logic [1:0]        row;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] base;
        logic [7:0]        char_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] byte_high_strobe;
        logic [7:0] byte_high;
        logic [7:0] byte_low_strobe;
        logic [7:0] byte_low;
        logic       last;
    } out_t;

    typedef struct packed {
        logic              refreshing;
        logic [ADDR_W-1:0] rd_addr;
    } status_t;

    function automatic logic [2:0] eff_rows(input cfg_t cfg);
        logic [2:0] r;
        r = cfg.rows;
        if (cfg.rows == 3'd0)
            r = 3'd1;
        else if (cfg.rows > 3'(MAX_ROWS))
            r = 3'(MAX_ROWS);
        return r;
    endfunction

    function automatic logic [4:0] eff_cols(input cfg_t cfg);
        logic [4:0] c;
        c = cfg.cols;
        if (cfg.cols == 5'd0)
            c = 5'd1;
        else if (cfg.cols > 5'(MAX_COLS))
            c = 5'(MAX_COLS);
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] store_total(input cfg_t cfg);
        logic [7:0] prod;
        prod = {5'd0, eff_rows(cfg)} * {3'd0, eff_cols(cfg)};
        return prod[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] init_cmd(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h33;
            4'd1:    v = 8'h33;
            4'd2:    v = 8'h32;
            4'd3:    v = 8'h20;
            4'd4:    v = 8'h06;
            4'd5:    v = 8'h0C;
            4'd6:    v = 8'h14;
            4'd7:    v = 8'h28;
            4'd8:    v = 8'h01;
            4'd9:    v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] line_base(input logic [1:0] row);
        logic [7:0] v;
        case (row)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h40;
            2'd2:    v = 8'h14;
            2'd3:    v = 8'h54;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Split one display byte into the expander address and four nibble bytes
    function automatic out_t format_byte(input cfg_t cfg, input logic [7:0] value,
                                         input logic is_data, input logic last);
        out_t       o;
        logic [7:0] flags;
        logic [7:0] hi;
        logic [7:0] lo;
        flags = (cfg.backlight_on ? cfg.backlight_mask : 8'h00)
              | (is_data ? cfg.rs_mask : 8'h00);
        hi = (value & NIBBLE_MASK) | flags;
        lo = ({value[3:0], 4'h0} & NIBBLE_MASK) | flags;
        o.address_byte     = {cfg.i2c_address, 1'b0};
        o.byte_high_strobe = hi | cfg.enable_mask;
        o.byte_high        = hi;
        o.byte_low_strobe  = lo | cfg.enable_mask;
        o.byte_low         = lo;
        o.last             = last;
        return o;
    endfunction

endpackage

`default_nettype wire

[sv/clbr_front.sv]
// Front end: takes requests, reduces row and column modulo the geometry with a
// bit-serial remainder unit, and pushes classified requests. Uses clbr_pkg.
`default_nettype none

module clbr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire clbr_pkg::cfg_t cfg,
    input  wire logic          push,
    output logic               full,
    input  wire logic [2:0]    kind,
    input  wire logic [7:0]    row,
    input  wire logic [7:0]    col,
    input  wire logic [7:0]    char_code,
    input  wire logic          q_full,
    output logic               q_push,
    output clbr_pkg::cmd_t     q_cmd
);
    import clbr_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t    state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] rem_r_reg, rem_r_next;
    logic [7:0] rem_c_reg, rem_c_next;
    logic [7:0] ch_reg, ch_next;

    logic [2:0]  nr;
    logic [4:0]  nc;
    logic [10:0] div_r;
    logic [12:0] div_c;
    logic        kind_ok;
    logic [6:0]  base;

    assign nr      = eff_rows(cfg);
    assign nc      = eff_cols(cfg);
    assign div_r   = {8'd0, nr} << step_reg;
    assign div_c   = {8'd0, nc} << step_reg;
    assign kind_ok = kind_reg inside {[KIND_INIT:KIND_REFRESH]};
    assign base    = 7'({5'd0, rem_r_reg[1:0]} * {2'd0, nc});

    assign full = (state_reg != F_IDLE);

    always_comb
    begin
        q_cmd.kind      = kind_t'(kind_reg);
        q_cmd.row       = rem_r_reg[1:0];
        q_cmd.base      = base;
        q_cmd.pos       = base + {2'd0, rem_c_reg[4:0]};
        q_cmd.char_code = ch_reg;
        q_push          = (state_reg == F_PUSH) && kind_ok && !q_full;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        rem_r_next = rem_r_reg;
        rem_c_next = rem_c_reg;
        ch_next    = ch_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    kind_next  = kind;
                    rem_r_next = row;
                    rem_c_next = col;
                    ch_next    = char_code;
                    step_next  = 3'd7;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                // one restoring-remainder step for each operand
                if ({3'd0, rem_r_reg} >= div_r)
                    rem_r_next = rem_r_reg - div_r[7:0];
                if ({5'd0, rem_c_reg} >= div_c)
                    rem_c_next = rem_c_reg - div_c[7:0];
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                // drop unknown kinds, otherwise hold until the queue has room
                if (!kind_ok || !q_full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 3'd0;
            kind_reg  <= 3'd0;
            rem_r_reg <= 8'd0;
            rem_c_reg <= 8'd0;
            ch_reg    <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
            rem_r_reg <= rem_r_next;
            rem_c_reg <= rem_c_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

`default_nettype wire

[sv/clbr_queue.sv]
// Two-entry request queue between the front and the back end.
// Uses clbr_pkg for the request type.
`default_nettype none

module clbr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire clbr_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output clbr_pkg::cmd_t      pop_cmd,
    output logic                empty
);
    import clbr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

[sv/clbr_back.sv]
// Back end: owns the screen store, the string cursor and the result register;
// runs init, store writes, clears and row refreshes. Uses clbr_pkg.
`default_nettype none

module clbr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire clbr_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    output logic                q_pop,
    input  wire clbr_pkg::cmd_t q_cmd,
    input  wire logic           pop,
    output logic                empty,
    output clbr_pkg::out_t      result,
    output clbr_pkg::status_t   status
);
    import clbr_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INIT,
        B_CMD,
        B_READ,
        B_DATA
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [4:0]        j_reg, j_next;
    logic [1:0]        row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    out_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [7:0]              mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]  valid_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_valid_reg;

    logic [ADDR_W-1:0] total;
    logic [4:0]        nc;
    logic [ADDR_W-1:0] rd_addr;
    logic              slot_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr_en;
    logic [ADDR_W-1:0] cur_pos;
    logic [ADDR_W-1:0] cur_inc;
    logic [ADDR_W-1:0] pos_inc;
    logic [7:0]        store_byte;

    assign total      = store_total(cfg);
    assign nc         = eff_cols(cfg);
    assign rd_addr    = base_reg + {2'd0, j_reg};
    assign slot_free  = !out_valid_reg || pop;
    assign cur_pos    = (cursor_reg >= total) ? '0 : cursor_reg;
    assign cur_inc    = (cur_pos + 1'b1 >= total) ? '0 : cur_pos + 1'b1;
    assign pos_inc    = (q_cmd.pos + 1'b1 >= total) ? '0 : q_cmd.pos + 1'b1;
    assign store_byte = rd_valid_reg ? rd_data_reg : SPACE_CHAR;

    assign empty             = !out_valid_reg;
    assign result            = out_reg;
    assign status.refreshing = (state_reg == B_READ) || (state_reg == B_DATA);
    assign status.rd_addr    = rd_addr;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        cursor_next    = cursor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = q_cmd.pos;
        clr_en         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        KIND_INIT:
                        begin
                            clr_en     = 1'b1;
                            j_next     = 5'd0;
                            state_next = B_INIT;
                        end
                        KIND_PLACE:
                        begin
                            wr_en       = 1'b1;
                            cursor_next = q_cmd.pos;
                        end
                        KIND_STRING_START:
                        begin
                            cursor_next = q_cmd.pos;
                            if (q_cmd.char_code != 8'd0)
                            begin
                                wr_en       = 1'b1;
                                cursor_next = pos_inc;
                            end
                        end
                        KIND_STRING_NEXT:
                        begin
                            if (q_cmd.char_code != 8'd0)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = cur_pos;
                                cursor_next = cur_inc;
                            end
                        end
                        KIND_CLEAR:
                            clr_en = 1'b1;
                        KIND_REFRESH:
                        begin
                            row_next   = q_cmd.row;
                            base_next  = q_cmd.base;
                            state_next = B_CMD;
                        end
                        default:
                            state_next = B_IDLE;
                    endcase
                end
            end
            B_INIT:
            begin
                if (slot_free)
                begin
                    out_next = format_byte(cfg, init_cmd(j_reg[3:0]), 1'b0,
                                           j_reg == 5'(INIT_COUNT - 1));
                    out_valid_next = 1'b1;
                    j_next = j_reg + 5'd1;
                    if (j_reg == 5'(INIT_COUNT - 1))
                        state_next = B_IDLE;
                end
            end
            B_CMD:
            begin
                if (slot_free)
                begin
                    out_next = format_byte(cfg, SET_DDRAM | line_base(row_reg), 1'b0, 1'b0);
                    out_valid_next = 1'b1;
                    j_next         = 5'd0;
                    state_next     = B_READ;
                end
            end
            B_READ:
                state_next = B_DATA;
            B_DATA:
            begin
                if (slot_free)
                begin
                    out_next = format_byte(cfg, store_byte, 1'b1, j_reg == nc - 5'd1);
                    out_valid_next = 1'b1;
                    if (j_reg == nc - 5'd1)
                        state_next = B_IDLE;
                    else
                    begin
                        j_next     = j_reg + 5'd1;
                        state_next = B_READ;
                    end
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            j_reg         <= 5'd0;
            row_reg       <= 2'd0;
            base_reg      <= '0;
            cursor_reg    <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            cursor_reg    <= cursor_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= q_cmd.char_code;
        rd_data_reg <= mem[rd_addr];
    end

    // Entry valid bits: an entry never written since reset or clear reads as space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            else if (clr_en)
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (ADDR_W'(i) < total)
                        valid_reg[i] <= 1'b0;
                end
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/char_lcd_buffer_refresh_top.sv]
// Flow: a request reaches the queue after 8 remainder steps for row and column, then the push;
// the back pops it once it is back in its idle state.
// Pacing: the front takes a new request only once the last one has left it, which bounds
// store writes, clears and unknown kinds; init gives its 10 results one per cycle while the
// result slot is free; a row refresh gives one command, then a store read and format per column.
// Reset: registers take their defaults, the cursor zero; valid bits make the store read spaces.
`default_nettype none

module char_lcd_buffer_refresh_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request side
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  char_code,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       address_byte,
    output logic [7:0]       byte_high_strobe,
    output logic [7:0]       byte_high,
    output logic [7:0]       byte_low_strobe,
    output logic [7:0]       byte_low,
    output logic             last
);
    import clbr_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    reg_index_t cfg_index;

    cmd_t    fq_cmd, qb_cmd;
    logic    fq_push, fq_full;
    logic    qb_pop, qb_empty;
    out_t    result;
    status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    // Register writes; addresses past the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows           <= 3'd2;
            cfg_reg.cols           <= 5'd16;
            cfg_reg.backlight_on   <= 1'b1;
            cfg_reg.i2c_address    <= 7'd39;
            cfg_reg.rs_mask        <= 8'h01;
            cfg_reg.enable_mask    <= 8'h04;
            cfg_reg.backlight_mask <= 8'h08;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROWS:           cfg_reg.rows           <= pwdata[2:0];
                REG_COLS:           cfg_reg.cols           <= pwdata[4:0];
                REG_BACKLIGHT_ON:   cfg_reg.backlight_on   <= pwdata[0];
                REG_I2C_ADDRESS:    cfg_reg.i2c_address    <= pwdata[6:0];
                REG_RS_MASK:        cfg_reg.rs_mask        <= pwdata[7:0];
                REG_ENABLE_MASK:    cfg_reg.enable_mask    <= pwdata[7:0];
                REG_BACKLIGHT_MASK: cfg_reg.backlight_mask <= pwdata[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        case (cfg_index)
            REG_ROWS:           prdata = {29'd0, cfg_reg.rows};
            REG_COLS:           prdata = {27'd0, cfg_reg.cols};
            REG_BACKLIGHT_ON:   prdata = {31'd0, cfg_reg.backlight_on};
            REG_I2C_ADDRESS:    prdata = {25'd0, cfg_reg.i2c_address};
            REG_RS_MASK:        prdata = {24'd0, cfg_reg.rs_mask};
            REG_ENABLE_MASK:    prdata = {24'd0, cfg_reg.enable_mask};
            REG_BACKLIGHT_MASK: prdata = {24'd0, cfg_reg.backlight_mask};
            default:            prdata = 32'd0;
        endcase
    end

    // Front: accept and classify each request
    clbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .char_code (char_code),
        .q_full    (fq_full),
        .q_push    (fq_push),
        .q_cmd     (fq_cmd)
    );

    // Short queue lets the front take the next request while the back works
    clbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .push_cmd (fq_cmd),
        .full     (fq_full),
        .pop      (qb_pop),
        .pop_cmd  (qb_cmd),
        .empty    (qb_empty)
    );

    // Back: store, cursor and result generation
    clbr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (qb_empty),
        .q_pop   (qb_pop),
        .q_cmd   (qb_cmd),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .status  (status)
    );

    assign address_byte     = result.address_byte;
    assign byte_high_strobe = result.byte_high_strobe;
    assign byte_high        = result.byte_high;
    assign byte_low_strobe  = result.byte_low_strobe;
    assign byte_low         = result.byte_low;
    assign last             = result.last;

`ifndef ASSERT_OFF
    // An accepted request keeps the front busy for its remainder steps
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front did not hold off after accepting a request");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fq_push |-> !fq_full)
        else $error("request pushed into full queue");

    // Refresh reads stay inside the screen store
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.refreshing |-> (status.rd_addr < ADDR_W'(STORE_DEPTH)))
        else $error("refresh read beyond the screen store");
`endif

endmodule

`default_nettype wire
